// ----- rtl/assert_macros.svh -----
// assertion macros used by the frontier detector result buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ofd assertion failed");
`define OFD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ofd assertion failed");
`else
`define OFD_ASSERT(lbl, clk, rst, prop)
`define OFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/ofd_pkg.sv -----
// types and constants of the occupancy frontier detector
package ofd_pkg;

   localparam int CELL_W      = 8;
   localparam int COORD_W     = 12;
   localparam int DIM_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int WINDOW_W    = 18;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCC_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0]         GRID_WIDTH_RESET  = 13'd4096;
   localparam logic [DIM_W-1:0]         GRID_HEIGHT_RESET = 13'd4096;
   localparam logic signed [CELL_W-1:0] THRESHOLD_RESET   = 8'sd100;
   localparam logic signed [CELL_W-1:0] UNKNOWN_VALUE     = -8'sd1;

   localparam int                CENTER_PASSABLE_BIT    = 9;
   localparam logic [WINDOW_W-1:0] NEIGHBOUR_UNKNOWN_MASK = 18'h15455;

   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 2;

   typedef struct packed {
      logic passable;
      logic unknown;
   } cls_type;

   typedef struct packed {
      cls_type upper;
      cls_type middle;
   } entry_type;

   typedef struct packed {
      cls_type            cls;
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
   } stage_type;

   typedef struct packed {
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               frontier;
      logic               frame_done;
   } result_type;

endpackage

// ----- rtl/occupancy_frontier_detect.sv -----
// top level of the streaming 8-neighbour occupancy frontier detector
// a result word passes the s1 stage register and then the result buffer before it is on rsp, behind queued words
// throughput: one cell word per cycle while req_ready is high, set by the single line store read-modify-write
// req_ready drops while the words in the three-word result buffer plus the word in flight reach three
// reset: counters, window and result buffer clear synchronously; grid registers return
// to width 4096, height 4096, threshold 100; line store contents are not cleared
module occupancy_frontier_detect
   import ofd_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CELL_W-1:0] req_cell_value,
   input  logic                     req_frame_start,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_W-1:0]       rsp_cell_x,
   output logic [COORD_W-1:0]       rsp_cell_y,
   output logic                     rsp_frontier,
   output logic                     rsp_frame_done,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DIM_W-1:0]         csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = CW + 1;
   localparam int HW  = RW + 1;
   localparam int WC  = (WW > DIM_W) ? WW : DIM_W;
   localparam int HC  = (HW > DIM_W) ? HW : DIM_W;
   localparam int XE  = (CW > COORD_W) ? CW : COORD_W;
   localparam int YE  = (RW > COORD_W) ? RW : COORD_W;

   logic [DIM_W-1:0]         grid_width_ff;
   logic [DIM_W-1:0]         grid_height_ff;
   logic signed [CELL_W-1:0] threshold_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] x_cur;
   logic [RW-1:0] y_cur;
   logic [WW-1:0] x_inc;
   logic [HW-1:0] y_inc;
   logic [WC-1:0] w_raw;
   logic [HC-1:0] h_raw;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [XE-1:0] xm1_ext;
   logic [YE-1:0] ym1_ext;

   logic       accept;
   stage_type  s0_item;
   stage_type  s1_item_ff;
   logic [CW-1:0] s1_addr_ff;
   logic       s1_valid_ff;

   entry_type  rd_data;
   entry_type  wr_data;
   logic       push;
   logic       pop;
   result_type result;
   result_type head;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W:0]   pending;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRID_WIDTH:    grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT:   grid_height_ff <= csr_data;
            CSR_OCC_THRESHOLD: threshold_ff   <= csr_data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp dimensions to 1..max
   always_comb begin
      w_raw = WC'(grid_width_ff);
      h_raw = HC'(grid_height_ff);
      if (w_raw == '0) w_eff = WW'(1);
      else if (w_raw > WC'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else w_eff = w_raw[WW-1:0];
      if (h_raw == '0) h_eff = HW'(1);
      else if (h_raw > HC'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
      else h_eff = h_raw[HW-1:0];
   end

   assign x_cur   = req_frame_start ? '0 : col_ff;
   assign y_cur   = req_frame_start ? '0 : row_ff;
   assign x_inc   = {1'b0, x_cur} + 1'b1;
   assign y_inc   = {1'b0, y_cur} + 1'b1;
   assign xm1_ext = XE'(x_cur - CW'(1));
   assign ym1_ext = YE'(y_cur - RW'(1));

   always_comb begin
      s0_item.cls.unknown  = (req_cell_value == UNKNOWN_VALUE);
      s0_item.cls.passable = !s0_item.cls.unknown && (req_cell_value < threshold_ff);
      s0_item.emit   = (x_cur >= CW'(2)) && ({1'b0, x_cur} < w_eff)
                       && (y_cur >= RW'(2)) && ({1'b0, y_cur} < h_eff);
      s0_item.last   = (x_inc == w_eff) && (y_inc == h_eff);
      s0_item.cell_x = xm1_ext[COORD_W-1:0];
      s0_item.cell_y = ym1_ext[COORD_W-1:0];
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (x_inc >= w_eff) begin
            col_in = '0;
            row_in = (y_inc >= h_eff) ? '0 : y_inc[RW-1:0];
         end else begin
            col_in = x_inc[CW-1:0];
            row_in = y_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s0_item;
         s1_addr_ff <= x_cur;
      end
   end

   // room for every word already in flight plus this one
   assign pending   = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid_ff};
   assign req_ready = (pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   ofd_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (x_cur),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   ofd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_item  (s1_item_ff),
      .rd_data  (rd_data),
      .wr_data  (wr_data),
      .push     (push),
      .result   (result)
   );

   assign pop = rsp_valid && rsp_ready;

   ofd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_cell_x     = head.cell_x;
   assign rsp_cell_y     = head.cell_y;
   assign rsp_frontier   = head.frontier;
   assign rsp_frame_done = head.frame_done;

endmodule

// ----- rtl/ofd_line_store.sv -----
// line store memory holding upper and middle row class bits per column
module ofd_line_store
   import ofd_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data
);

   entry_type mem [DEPTH];
   entry_type q_ff;
   entry_type byp_data_ff;
   logic      byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // same-cycle write to the address being read wins over the stale read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : q_ff;

endmodule

// ----- rtl/ofd_window.sv -----
// 3x3 class window, frontier test and line store write-back data
module ofd_window
   import ofd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_valid,
   input  stage_type  s1_item,
   input  entry_type  rd_data,
   output entry_type  wr_data,
   output logic       push,
   output result_type result
);

   logic [WINDOW_W-1:0] window_ff;
   logic [WINDOW_W-1:0] window_in;
   logic [5:0]          column;

   // bits 0-1 lower row, 2-3 middle row, 4-5 upper row
   assign column    = {rd_data.upper, rd_data.middle, s1_item.cls};
   assign window_in = {window_ff[WINDOW_W-7:0], column};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_valid) begin
         window_ff <= window_in;
      end
   end

   assign wr_data.upper  = rd_data.middle;
   assign wr_data.middle = s1_item.cls;

   assign push              = s1_valid && s1_item.emit;
   assign result.cell_x     = s1_item.cell_x;
   assign result.cell_y     = s1_item.cell_y;
   assign result.frame_done = s1_item.last;
   assign result.frontier   = window_in[CENTER_PASSABLE_BIT]
                              && ((window_in & NEIGHBOUR_UNKNOWN_MASK) != '0);

endmodule

// ----- rtl/ofd_out_fifo.sv -----
// three-word result buffer between the window stage and the rsp channel
module ofd_out_fifo
   import ofd_pkg::*;
`include "assert_macros.svh"
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  result_type            push_data,
   input  logic                  pop,
   output logic                  not_empty,
   output result_type            head,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type            buf_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
      logic [FIFO_PTR_W-1:0] r;
      if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = buf_ff[rd_ptr_ff];
   assign count     = count_ff;

   `OFD_ASSERT(a_count_bound, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `OFD_ASSERT(a_no_overflow, clock, reset, push |-> (count_ff < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
   `OFD_ASSERT(a_no_underflow, clock, reset, pop |-> not_empty)

endmodule

// ----- verif/tb_top.sv -----
// testbench for occupancy_frontier_detect: raster grids checked against a frontier predictor
`timescale 1ns / 1ps

module tb_top;
   import ofd_pkg::*;

   localparam int MAX_DIM = 4096;

   typedef struct packed {
      logic signed [CELL_W-1:0] value;
      logic                     sof;
      logic                     typed;
      result_type               want;
   } directed_row;

   localparam result_type NO_RESULT = '0;

   // two 3x3 grids with known answers, then restarts in the first row
   localparam directed_row DIRECTED_ROWS [24] = '{
      '{8'sd127, 1'b1, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{-8'sd128, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b1, '{12'd1, 12'd1, 1'b1, 1'b1}},
      '{UNKNOWN_VALUE, 1'b1, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{8'sd100, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b1, '{12'd1, 12'd1, 1'b0, 1'b1}},
      '{-8'sd128, 1'b1, 1'b0, NO_RESULT},
      '{8'sd0, 1'b1, 1'b0, NO_RESULT},
      '{8'sd99, 1'b0, 1'b0, NO_RESULT},
      '{UNKNOWN_VALUE, 1'b0, 1'b0, NO_RESULT},
      '{8'sd127, 1'b0, 1'b0, NO_RESULT},
      '{8'sd0, 1'b0, 1'b0, NO_RESULT}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [CELL_W-1:0] req_cell_value = '0;
   logic                     req_frame_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COORD_W-1:0]       rsp_cell_x;
   logic [COORD_W-1:0]       rsp_cell_y;
   logic                     rsp_frontier;
   logic                     rsp_frame_done;
   logic                     csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [DIM_W-1:0]         csr_data = '0;

   occupancy_frontier_detect dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_value  (req_cell_value),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_frontier    (rsp_frontier),
      .rsp_frame_done  (rsp_frame_done),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // frontier predictor state
   bit [1:0]                 upper_cls [MAX_DIM];
   bit [1:0]                 middle_cls [MAX_DIM];
   logic [WINDOW_W-1:0]      cls_window = '0;
   int                       col_pos = 0;
   int                       row_pos = 0;
   logic [DIM_W-1:0]         cfg_width = GRID_WIDTH_RESET;
   logic [DIM_W-1:0]         cfg_height = GRID_HEIGHT_RESET;
   logic signed [CELL_W-1:0] cfg_threshold = THRESHOLD_RESET;

   result_type               pending_results [$];
   int                       mismatches = 0;
   int                       results_seen = 0;
   int                       frontier_seen = 0;
   int                       grids_done = 0;
   int                       words_sent = 0;
   int                       phases = 0;
   bit                       gaps_on = 1'b1;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("status: fail");
      $finish;
   end

   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic bit frontier_step(input logic signed [CELL_W-1:0] value,
                                        input logic sof, output result_type res);
      int w;
      int h;
      int x;
      int y;
      cls_type cls;
      bit [1:0] up;
      bit [1:0] mid;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      cls.unknown = (value == UNKNOWN_VALUE);
      cls.passable = !cls.unknown && (value < cfg_threshold);
      up = upper_cls[x];
      mid = middle_cls[x];
      upper_cls[x] = mid;
      middle_cls[x] = cls;
      cls_window = {cls_window[WINDOW_W-7:0], up, mid, cls};
      res = '0;
      frontier_step = 1'b0;
      if (x >= 2 && x < w && y >= 2 && y < h) begin
         res.cell_x = COORD_W'(x - 1);
         res.cell_y = COORD_W'(y - 1);
         res.frontier = cls_window[CENTER_PASSABLE_BIT]
                        && ((cls_window & NEIGHBOUR_UNKNOWN_MASK) != '0);
         res.frame_done = (x == w - 1) && (y == h - 1);
         frontier_step = 1'b1;
      end
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall();
      if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_threshold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return -127;
      if (r < 30) return 127;
      if (r < 45) return 100;
      return int'($urandom_range(0, 254)) - 127;
   endfunction

   function automatic logic signed [CELL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return UNKNOWN_VALUE;
      if (r < 55) return CELL_W'(int'(cfg_threshold) + int'($urandom_range(0, 4)) - 2);
      if (r < 65) return '0;
      return CELL_W'($urandom());
   endfunction

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_GRID_WIDTH: cfg_width = data;
         CSR_GRID_HEIGHT: cfg_height = data;
         CSR_OCC_THRESHOLD: cfg_threshold = data[CELL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send_cell(input logic signed [CELL_W-1:0] value, input logic sof,
                            input logic typed, input result_type want);
      result_type res;
      int gap;
      req_valid <= 1'b1;
      req_cell_value <= value;
      req_frame_start <= sof;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (frontier_step(value, sof, res))
         pending_results.insert(pending_results.size(), typed ? want : res);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int w, input int h, input int thr, input bit new_grid,
                            input int n, input bit allow_gaps);
      int frame_len;
      bit sof;
      drain();
      if (new_grid) set_reg(CSR_GRID_WIDTH, DIM_W'(w));
      set_reg(CSR_GRID_HEIGHT, DIM_W'(h));
      set_reg(CSR_OCC_THRESHOLD, {{(DIM_W-CELL_W){1'b0}}, CELL_W'(thr)});
      csr_write <= 1'b0;
      phases++;
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      frame_len = clamp_dim(cfg_width) * clamp_dim(cfg_height);
      for (int i = 0; i < n; i++) begin
         sof = new_grid && (i == 0 || (i % frame_len == 0 && $urandom_range(0, 9) < 7));
         if (frame_len <= 400 && $urandom_range(0, 99) == 0) sof = 1'b1;
         send_cell(pick_value(), sof, 1'b0, NO_RESULT);
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got = '{rsp_cell_x, rsp_cell_y, rsp_frontier, rsp_frame_done};
      results_seen++;
      if (got.frontier === 1'b1) frontier_seen++;
      if (got.frame_done === 1'b1) grids_done++;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word x=%0d y=%0d frontier=%0d done=%0d",
                     got.cell_x, got.cell_y, got.frontier, got.frame_done);
      end else begin
         want = pending_results.pop_front();
         if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y
             || got.frontier !== want.frontier || got.frame_done !== want.frame_done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word %0d: want x=%0d y=%0d f=%0d d=%0d, got x=%0d y=%0d f=%0d d=%0d",
                        results_seen, want.cell_x, want.cell_y, want.frontier,
                        want.frame_done, got.cell_x, got.cell_y, got.frontier,
                        got.frame_done);
         end
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result();
      end
   end

   initial begin : receiver
      int stretch;
      bit choppy;
      bit held_long;
      stretch = 0;
      choppy = 1'b0;
      held_long = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (stretch == 0) begin
            stretch = $urandom_range(20, 200);
            choppy = ($urandom_range(0, 2) != 0);
         end
         stretch--;
         if (!held_long && results_seen >= 20) begin
            // long hold so the result buffer fills and req_ready drops
            held_long = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else if (choppy && $urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            repeat (pick_stall()) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int k;
      int w;
      int h;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_reg(CSR_GRID_WIDTH, 13'd3);
      set_reg(CSR_GRID_HEIGHT, 13'd3);
      csr_write <= 1'b0;
      foreach (DIRECTED_ROWS[i])
         send_cell(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].sof,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      run_phase(8, 6, 100, 1'b1, 240, 1'b0);
      while (words_sent < 1000) begin
         k = $urandom_range(0, 99);
         if (k < 10) begin
            // grids too small to hold an interior cell
            if ($urandom_range(0, 1)) begin
               w = $urandom_range(1, 2);
               h = $urandom_range(1, 8);
            end else begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 2);
            end
            run_phase(w, h, pick_threshold(), 1'b1, $urandom_range(10, 30), 1'b1);
         end else if (k < 20) begin
            // threshold and height change while the counters keep running
            run_phase(int'(cfg_width), $urandom_range(3, 10), pick_threshold(), 1'b0,
                      $urandom_range(20, 120), 1'b1);
         end else begin
            w = $urandom_range(3, 16);
            h = $urandom_range(3, 10);
            run_phase(w, h, pick_threshold(), 1'b1,
                      w * h * $urandom_range(1, 3) + $urandom_range(0, w), 1'b1);
         end
      end
      run_phase(MAX_DIM, 3, 127, 1'b1, 200, 1'b1);
      run_phase(3, MAX_DIM, -127, 1'b1, 200, 1'b1);

      drain();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatches++;
         $display("%0d expected words never arrived", pending_results.size());
      end
      $display("sent %0d cell words over %0d register settings, checked %0d result words",
               words_sent, phases + 1, results_seen);
      $display("saw %0d frontier cells and %0d completed grids, sizes 1 to 4096",
               frontier_seen, grids_done);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
